@@ rtl/fdf_pkg.sv @@
// Shared types and constants of the direct-form FIR filter.
// No dependencies; the MAC unit, the top level and the checker use it.
package fdf_pkg;

    // Delay-line and coefficient-store depth
    localparam int TAPS      = 16;
    localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W     = $clog2(TAPS + 1);

    // Field widths
    localparam int FUNC_W    = 1;
    localparam int CIDX_W    = 4;
    localparam int COEF_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 5;
    localparam int OUT_W     = 32;
    localparam int FRAC_W    = 14;

    // Arithmetic widths: one product, then the sum over all taps
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = PROD_W + TAP_IDX_W + 1;
    localparam int Q_W       = ACC_W - FRAC_W;
    localparam int QX_W      = (Q_W > OUT_W + 1) ? Q_W : OUT_W + 1;

    // Input tdata layout, lowest bit first
    localparam int CIDX_LSB   = 0;
    localparam int COEF_LSB   = CIDX_LSB + CIDX_W;
    localparam int SAMPLE_LSB = COEF_LSB + COEF_W;
    localparam int IN_BITS    = SAMPLE_LSB + SAMPLE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    // Item kinds carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

    localparam int CFG_RESET = 16;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Sequencer commands to the MAC unit
    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

endpackage

@@ rtl/fdf_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on fdf_pkg.
module fdf_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  fdf_pkg::mac_ctrl_t  ctrl,
    input  fdf_pkg::sample_t    op_sample,
    input  fdf_pkg::coef_t      op_coef,
    output fdf_pkg::acc_t       acc
);

    logic signed [fdf_pkg::PROD_W-1:0] prod_reg;
    logic signed [fdf_pkg::PROD_W-1:0] prod_next;
    logic                              prod_valid_reg;
    fdf_pkg::acc_t                     acc_reg;
    fdf_pkg::acc_t                     acc_next;

    assign prod_next = op_sample * op_coef;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + fdf_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue && !ctrl.clear;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/fir_filter_direct_form.sv @@
// Top level of the direct-form FIR filter: delay line, coefficient store,
// sequencer and output register. Depends on fdf_pkg and fdf_mac.
//
// Usage:
//   s_* is the input stream. s_tuser selects the kind of beat: a load beat
//   writes coef_value into tap coef_index and gives no output; a sample beat
//   shifts sample into the delay line and gives one output beat.
//   m_* carries the filtered value in m_tdata and the saturation flag in
//   m_tuser. cfg_* writes taps_in_use (0 acts as 1, above the depth as the
//   depth); write it only while the filter is idle.
// Sequence:
//   A load beat leaves s_tready high. A sample beat holds s_tready low while
//   one shared multiplier visits one tap per cycle over the N taps in use,
//   then through a step that drains the product register and a final step
//   that scales, saturates and loads the output register; that final step
//   waits while the output register still holds an untaken beat. m_tvalid
//   rises once the output register is loaded, and only then is the next sample taken.
// Reset:
//   rst_n clears the delay line, the coefficients, taps_in_use (to 16) and
//   the valid flag of the output register.
// Stall:
//   The output register holds its beat until m_tready. A new sample is still
//   taken and computed meanwhile; its result waits in the final step until
//   the output register frees up.
module fir_filter_direct_form (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] coef_index, [19:4] coef_value, [35:20] sample, [39:36] zero
    input  logic [fdf_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] func
    input  logic [fdf_pkg::FUNC_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] filtered
    output logic [fdf_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] saturated
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdf_pkg::CFG_W-1:0]        cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam int unsigned FRAC_MASK = (1 << fdf_pkg::FRAC_W) - 1;
    localparam logic signed [fdf_pkg::QX_W-1:0] Q_MAX = fdf_pkg::QX_W'(64'sd2147483647);
    localparam logic signed [fdf_pkg::QX_W-1:0] Q_MIN = fdf_pkg::QX_W'(-64'sd2147483648);

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [fdf_pkg::CNT_W-1:0]        k_reg;
    logic [fdf_pkg::CNT_W-1:0]        k_next;
    logic [fdf_pkg::CNT_W-1:0]        n_reg;
    logic [fdf_pkg::CNT_W-1:0]        n_next;
    logic [fdf_pkg::CFG_W-1:0]        taps_cfg_reg;
    fdf_pkg::sample_t                 delay_reg [fdf_pkg::TAPS];
    fdf_pkg::coef_t                   coef_reg  [fdf_pkg::TAPS];

    logic                             out_valid_reg;
    logic [fdf_pkg::OUT_W-1:0]        out_data_reg;
    logic                             out_sat_reg;

    logic                             in_beat;
    logic                             load_beat;
    logic                             sample_beat;
    logic                             load_ok;
    logic [fdf_pkg::CIDX_W-1:0]       in_cidx;
    fdf_pkg::coef_t                   in_coef;
    fdf_pkg::sample_t                 in_sample;
    logic [fdf_pkg::TAP_IDX_W-1:0]    load_addr;
    logic [fdf_pkg::TAP_IDX_W-1:0]    tap_addr;
    logic [fdf_pkg::CNT_W-1:0]        n_clamped;
    logic                             out_load;

    fdf_pkg::mac_ctrl_t               mac_ctrl;
    fdf_pkg::acc_t                    acc;
    fdf_pkg::acc_t                    acc_adj;
    logic signed [fdf_pkg::Q_W-1:0]   quot;
    logic signed [fdf_pkg::QX_W-1:0]  quot_x;
    logic [fdf_pkg::OUT_W-1:0]        res_data;
    logic                             res_sat;

    // Input beat decode
    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign in_beat     = s_tvalid && s_tready;
    assign load_beat   = in_beat && (s_tuser == fdf_pkg::FUNC_LOAD);
    assign sample_beat = in_beat && (s_tuser == fdf_pkg::FUNC_SAMPLE);

    assign in_cidx   = s_tdata[fdf_pkg::CIDX_LSB +: fdf_pkg::CIDX_W];
    assign in_coef   = s_tdata[fdf_pkg::COEF_LSB +: fdf_pkg::COEF_W];
    assign in_sample = s_tdata[fdf_pkg::SAMPLE_LSB +: fdf_pkg::SAMPLE_W];

    // Drop loads aimed past the end of the store
    assign load_ok   = 32'(in_cidx) < 32'(fdf_pkg::TAPS);
    assign load_addr = fdf_pkg::TAP_IDX_W'(in_cidx);

    // Taps in use: zero acts as one, anything past the depth as the depth
    always_comb
    begin
        if (taps_cfg_reg == '0)
        begin
            n_clamped = fdf_pkg::CNT_W'(1);
        end
        else if (32'(taps_cfg_reg) > 32'(fdf_pkg::TAPS))
        begin
            n_clamped = fdf_pkg::CNT_W'(fdf_pkg::TAPS);
        end
        else
        begin
            n_clamped = fdf_pkg::CNT_W'(taps_cfg_reg);
        end
    end

    assign tap_addr = k_reg[fdf_pkg::TAP_IDX_W-1:0];
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.issue = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_beat)
                begin
                    mac_ctrl.clear = 1'b1;
                    k_next         = '0;
                    n_next         = n_clamped;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                mac_ctrl.issue = 1'b1;
                if (k_reg == n_reg - fdf_pkg::CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + fdf_pkg::CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fdf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .op_sample (delay_reg[tap_addr]),
        .op_coef   (coef_reg[tap_addr]),
        .acc       (acc)
    );

    // Scale by 2^-14 toward zero: bias negative sums before the shift
    assign acc_adj = acc + (acc[fdf_pkg::ACC_W-1] ? fdf_pkg::ACC_W'(FRAC_MASK) : '0);
    assign quot    = acc_adj[fdf_pkg::ACC_W-1:fdf_pkg::FRAC_W];
    assign quot_x  = fdf_pkg::QX_W'(quot);

    // Clamp to the 32-bit range and flag it
    always_comb
    begin
        res_sat = 1'b0;
        if (quot_x > Q_MAX)
        begin
            res_data = fdf_pkg::OUT_W'(Q_MAX);
            res_sat  = 1'b1;
        end
        else if (quot_x < Q_MIN)
        begin
            res_data = fdf_pkg::OUT_W'(Q_MIN);
            res_sat  = 1'b1;
        end
        else
        begin
            res_data = fdf_pkg::OUT_W'(quot_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            n_reg        <= fdf_pkg::CNT_W'(1);
            taps_cfg_reg <= fdf_pkg::CFG_W'(fdf_pkg::CFG_RESET);
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                taps_cfg_reg <= cfg_data;
            end
        end
    end

    // Delay line: the whole line shifts on every sample beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fdf_pkg::TAPS; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (sample_beat)
        begin
            delay_reg[0] <= in_sample;
            for (int i = 1; i < fdf_pkg::TAPS; i++)
            begin
                delay_reg[i] <= delay_reg[i-1];
            end
        end
    end

    // Coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fdf_pkg::TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (load_beat && load_ok)
        begin
            coef_reg[load_addr] <= in_coef;
        end
    end

    // Output register: hold the beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_data;
            out_sat_reg  <= res_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fdf_pkg::OUT_DATA_W'(out_data_reg);
    assign m_tuser  = out_sat_reg;

endmodule

@@ rtl/fdf_checker.sv @@
// Port-level checks of the FIR filter, bound to the top level.
// Depends on fdf_pkg and fir_filter_direct_form.
module fdf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [fdf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [fdf_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [fdf_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [fdf_pkg::CFG_W-1:0]        cfg_data
);

    // A sample beat starts the tap sweep, so the input side goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == fdf_pkg::FUNC_SAMPLE) |=> !s_tready)
    else $error("input still ready after a sample beat");

    // A stalled output beat holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

    // The saturation flag only comes with a clamped value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata[31:0] == 32'h7fff_ffff) || (m_tdata[31:0] == 32'h8000_0000))
    else $error("saturation flag without a clamped value");

    // Reset empties the output register by the next edge
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
    else $error("output valid during reset");

endmodule

bind fir_filter_direct_form fdf_checker u_fdf_checker (.*);
